### hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the FFT block.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/r2fft_pkg.sv
// Package of the radix-2 FFT block: item types, sequencer states, constants.
// Depends on nothing.
`timescale 1ns / 1ps
package r2fft_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam logic [3:0] CFG_RESET = 4'd9;

  typedef struct packed {
    logic               command;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic        [8:0]  bin_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] bin_re;
    logic signed [31:0] bin_im;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDOUT,
    ST_SW_RD,
    ST_SW_W1,
    ST_SW_W2,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WA,
    ST_BF_WB
  } state_e;

endpackage

### hw/rtl/r2fft_ram.sv
// Generic RAM: one write port, two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps
module r2fft_ram #(
  parameter int Width = 64,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  // Write, then register both reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### hw/rtl/radix2_fft.sv
// Top level of the radix-2 DIT FFT: sample store, sequencer, butterfly unit.
// Depends on r2fft_pkg, r2fft_ram and assert_macros.svh.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------
//  in       | input     | in_valid_i/in_stall_o | in_item_t
//  out      | output    | out_valid_o/out_stall_i | out_item_t
//  cfg      | input     | cfg_valid_i/cfg_ready_o | 4-bit log2 size
//
// A load writes the store directly; a read goes through the store's read
// register, then the result register. The load that fills N entries starts
// the transform: a swap pass that writes back each bit-reversed pair, then
// (N/2)log2(N) butterflies over the one shared butterfly unit and the
// store's write port. No item is accepted during the transform or while a
// read waits on a stalled result. Reset clears the control state, not the store.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module radix2_fft
  import r2fft_pkg::*;
#(
  parameter int MAX_POINTS = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  localparam int AW   = $clog2(MAX_POINTS + 1) - 1;
  localparam int M    = 1 << AW;
  localparam int HM   = M / 2;
  localparam int TWA  = (AW > 1) ? AW - 1 : 1;
  localparam int LW   = $clog2(AW + 1);

  // Shift-and-subtract division for twiddle generation; operands are never negative
  function automatic longint udiv_f(longint num, longint den);
    longint q, r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 64'sd1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'sd1;
      end
    end
    return q;
  endfunction

  // Twiddle generation at elaboration: fixed-point Taylor series in Q30
  function automatic longint taylor_f(longint x, bit odd);
    longint x2, term, sum, n;
    x2 = (x * x) >>> 30;
    term = odd ? x : (64'sd1 <<< 30);
    sum = 0;
    n = odd ? 1 : 0;
    for (int i = 0; i < 14; i++) begin
      if (i[0]) sum = sum - term;
      else sum = sum + term;
      term = udiv_f((term * x2) >>> 30, (n + 1) * (n + 2));
      n = n + 2;
    end
    return sum;
  endfunction

  function automatic longint q15_f(longint v);
    longint t;
    t = (v < 0) ? 64'sd0 : v;
    return (t + (64'sd1 <<< 14)) >>> 15;
  endfunction

  function automatic longint twid_f(int k, bit odd);
    longint kk, th, r;
    bit flip;
    kk = k;
    flip = 1'b0;
    if (4 * k > M) begin
      kk = HM - k;
      flip = 1'b1;
    end
    th = (2 * PI_Q30 * kk) >>> AW;
    r = q15_f(taylor_f(th, odd));
    if (flip && !odd) r = -r;
    return r;
  endfunction

  logic signed [16:0] rom_cos [HM];
  logic signed [16:0] rom_sin [HM];

  for (genvar g = 0; g < HM; g++) begin : g_rom
    localparam longint CosV = twid_f(g, 1'b0);
    localparam longint SinV = twid_f(g, 1'b1);
    assign rom_cos[g] = CosV[16:0];
    assign rom_sin[g] = SinV[16:0];
  end

  state_e state_q, state_d;
  logic [3:0]    cfg_q;
  logic [AW-1:0] load_cnt_q;
  logic [AW-1:0] cnt_q;
  logic [LW-1:0] stage_q;
  logic [AW-1:0] rd_addr_q;
  logic [63:0]   hold_q;
  logic signed [16:0] wr_q, wi_q;
  logic signed [48:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [34:0] vr_q, vi_q;
  logic          out_valid_q;
  out_item_t     out_item_q;

  logic          we;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [63:0]   wdata, rdata_a, rdata_b;

  r2fft_ram #(.Width(64), .Depth(M)) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // Clamp the length register to 1..AW
  logic [LW-1:0] act_l;
  always_comb begin
    if (cfg_q == 4'd0) act_l = LW'(1);
    else if (32'(cfg_q) > AW) act_l = LW'(AW);
    else act_l = LW'(cfg_q);
  end

  logic [AW-1:0] mask, low, half, a_addr, b_addr, rev_full, rev;
  logic [TWA-1:0] tw_idx;
  always_comb begin
    mask = {AW{1'b1}} >> (LW'(AW) - act_l);
    low  = ~({AW{1'b1}} << (stage_q - LW'(1)));
    half = AW'(1) << (stage_q - LW'(1));
    a_addr = ((cnt_q & ~low) << 1) | (cnt_q & low);
    b_addr = a_addr | half;
    tw_idx = TWA'((cnt_q & low) << (LW'(AW) - stage_q));
    for (int i = 0; i < AW; i++) begin
      rev_full[i] = cnt_q[AW-1-i];
    end
    rev = rev_full >> (LW'(AW) - act_l);
  end

  logic in_acc, out_free, last_i, last_j, last_s;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_i   = (cnt_q == mask);
  assign last_j   = (cnt_q == (mask >> 1));
  assign last_s   = (stage_q == act_l);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item_i.command == CMD_READ) state_d = ST_RDOUT;
          else if (load_cnt_q >= mask) state_d = ST_SW_RD;
        end
      end
      ST_RDOUT:  if (out_free) state_d = ST_IDLE;
      ST_SW_RD: begin
        if (rev > cnt_q) state_d = ST_SW_W1;
        else if (last_i) state_d = ST_BF_RD;
      end
      ST_SW_W1:  state_d = ST_SW_W2;
      ST_SW_W2:  state_d = last_i ? ST_BF_RD : ST_SW_RD;
      ST_BF_RD:  state_d = ST_BF_MUL;
      ST_BF_MUL: state_d = ST_BF_ADD;
      ST_BF_ADD: state_d = ST_BF_WA;
      ST_BF_WA:  state_d = ST_BF_WB;
      ST_BF_WB:  state_d = (last_j && last_s) ? ST_IDLE : ST_BF_RD;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Store port controls
  logic signed [31:0] ar, ai;
  assign ar = hold_q[63:32];
  assign ai = hold_q[31:0];
  always_comb begin
    we = 1'b0;
    waddr = cnt_q;
    wdata = hold_q;
    raddr_a = rd_addr_q;
    raddr_b = rev;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = out_valid_q && out_stall_i;
        raddr_a = AW'(in_item_i.bin_index) & mask;
        we = in_acc && (in_item_i.command == CMD_LOAD);
        waddr = load_cnt_q;
        wdata = {32'(in_item_i.sample_re), 32'(in_item_i.sample_im)};
      end
      ST_SW_RD: raddr_a = cnt_q;
      ST_SW_W1: begin
        we = 1'b1;
        wdata = rdata_b;
      end
      ST_SW_W2: begin
        we = 1'b1;
        waddr = rev;
      end
      ST_BF_RD: begin
        raddr_a = a_addr;
        raddr_b = b_addr;
      end
      ST_BF_WA: begin
        we = 1'b1;
        waddr = a_addr;
        wdata = {ar + vr_q[31:0], ai + vi_q[31:0]};
      end
      ST_BF_WB: begin
        we = 1'b1;
        waddr = b_addr;
        wdata = {ar - vr_q[31:0], ai - vi_q[31:0]};
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      load_cnt_q  <= '0;
      cnt_q       <= '0;
      stage_q     <= LW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
      if (state_q == ST_RDOUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_item_i.command == CMD_LOAD) begin
            load_cnt_q <= (load_cnt_q >= mask) ? '0 : load_cnt_q + AW'(1);
            cnt_q   <= '0;
            stage_q <= LW'(1);
          end
        end
        ST_SW_RD: begin
          if (!(rev > cnt_q)) cnt_q <= last_i ? '0 : cnt_q + AW'(1);
        end
        ST_SW_W2: cnt_q <= last_i ? '0 : cnt_q + AW'(1);
        ST_BF_WB: begin
          if (last_j) begin
            cnt_q   <= '0;
            stage_q <= stage_q + LW'(1);
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: read address, operand hold, result, butterfly pipeline
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) rd_addr_q <= AW'(in_item_i.bin_index) & mask;
    if (state_q == ST_SW_W1) hold_q <= rdata_a;
    if (state_q == ST_RDOUT && out_free) begin
      out_item_q.bin_re <= rdata_a[63:32];
      out_item_q.bin_im <= rdata_a[31:0];
    end
    if (state_q == ST_BF_RD) begin
      wr_q <= rom_cos[tw_idx];
      wi_q <= -rom_sin[tw_idx];
    end
    if (state_q == ST_BF_MUL) begin
      hold_q <= rdata_a;
      p_rr_q <= 49'($signed(rdata_b[63:32])) * 49'(wr_q);
      p_ii_q <= 49'($signed(rdata_b[31:0])) * 49'(wi_q);
      p_ri_q <= 49'($signed(rdata_b[63:32])) * 49'(wi_q);
      p_ir_q <= 49'($signed(rdata_b[31:0])) * 49'(wr_q);
    end
    if (state_q == ST_BF_ADD) begin
      vr_q <= 35'((50'(p_rr_q) - 50'(p_ii_q) + 50'sd16384) >>> 15);
      vi_q <= 35'((50'(p_ri_q) + 50'(p_ir_q) + 50'sd16384) >>> 15);
    end
  end

  // Take the length register only between items
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `AST_NEXT(a_read_goes_out, in_acc && in_item_i.command == CMD_READ, state_q == ST_RDOUT, "read item did not reach result stage")
  `AST_SAME(a_swap_order, state_q == ST_SW_W1, rev > cnt_q, "swap issued for non-ascending pair")
  `AST_SAME(a_busy_stalls, state_q != ST_IDLE, in_stall_o, "item accepted while busy")
  `AST_SAME(a_stage_range, state_q == ST_BF_RD, stage_q >= LW'(1) && stage_q <= act_l, "butterfly stage out of range")

endmodule
